FILE: design/wru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wru_pkg;

   localparam int ADDR_W = 32;
   localparam int OP_W   = 2;
   localparam int KIND_W = 2;

   localparam logic [OP_W-1:0] REQ_CHECK  = 2'd0;
   localparam logic [OP_W-1:0] REQ_ADD    = 2'd1;
   localparam logic [OP_W-1:0] REQ_REMOVE = 2'd2;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   req_type;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] len;
      logic [KIND_W-1:0] wp_kind;
      logic              access_wr;
   } req_item_type;

   typedef struct packed {
      logic              status;
      logic              hit;
      logic [ADDR_W-1:0] hit_addr;
   } rsp_item_type;

   // item travelling down the row of slots
   typedef struct packed {
      logic              valid;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] len;
      logic [ADDR_W-1:0] sum;
      logic [KIND_W-1:0] kind;
      logic              wr;
      logic              done;
      logic              wrote;
   } token_type;

endpackage

`default_nettype wire

FILE: design/wru_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module wru_cell #(
   parameter int ENTRIES = 32,
   parameter int INDEX   = 0
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [$clog2(ENTRIES+1)-1:0]     used_count,
   input  wire wru_pkg::token_type               tok_in,
   output wru_pkg::token_type                    tok_out
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [wru_pkg::ADDR_W-1:0] addr_ff, len_ff, end_ff;
   logic [wru_pkg::ADDR_W-1:0] addr_in, len_in, end_in;
   logic [wru_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic                       active_ff, active_in;
   logic                       load;
   wru_pkg::token_type         tok_ff, tok_upd_in;

   logic kind_ok, same, take, overlap, dir_ok, cell_hit;

   always_comb begin
      kind_ok  = (tok_in.kind <= wru_pkg::KIND_ACCESS);
      same     = active_ff && (addr_ff == tok_in.addr) && (len_ff == tok_in.len)
                 && (kind_ff == tok_in.kind);
      // next unused slot; only reached when no identical slot was found upstream
      take     = (used_count == CNT_W'(INDEX)) && kind_ok;
      overlap  = !(tok_in.sum <= addr_ff) && !(tok_in.addr >= end_ff);
      dir_ok   = (kind_ff == wru_pkg::KIND_ACCESS)
                 || ((kind_ff == wru_pkg::KIND_WRITE) && tok_in.wr)
                 || ((kind_ff == wru_pkg::KIND_READ) && !tok_in.wr);
      cell_hit = active_ff && overlap && dir_ok;

      tok_upd_in = tok_in;
      active_in  = active_ff;
      load       = 1'b0;
      addr_in    = tok_in.addr;
      len_in     = tok_in.len;
      end_in     = tok_in.sum;
      kind_in    = tok_in.kind;

      if (tok_in.valid && !tok_in.done) begin
         case (tok_in.op)
            wru_pkg::REQ_CHECK: begin
               if (cell_hit) tok_upd_in.done = 1'b1;
            end
            wru_pkg::REQ_ADD: begin
               if (kind_ok && same) begin
                  tok_upd_in.done = 1'b1;
               end else if (take) begin
                  tok_upd_in.done  = 1'b1;
                  tok_upd_in.wrote = 1'b1;
                  active_in        = 1'b1;
                  load             = 1'b1;
               end
            end
            wru_pkg::REQ_REMOVE: begin
               if (kind_ok && same) begin
                  tok_upd_in.done = 1'b1;
                  active_in       = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         active_ff <= active_in;
         tok_ff    <= tok_upd_in;
      end
      if (load) begin
         addr_ff <= addr_in;
         len_ff  <= len_in;
         end_ff  <= end_in;
         kind_ff <= kind_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

FILE: design/watchpoint_range_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Watchpoint table of ENTRIES slots, one slot per cell in a row.
// Request channel: req_item (type, address, length, kind, direction) is
// taken at a rising edge with start high and busy low. busy then stays high
// until the result appears.
// Result channel: rsp_item is shown for exactly one cycle with rsp_valid
// high; the receiver cannot stall, so it must take it in that cycle.
// An item walks the row one cell per cycle: it is registered at the head,
// passes ENTRIES cells and is then registered onto the result ports; busy
// falls as the result appears. Only one item is in the row at a time; a new
// item can be taken in the cycle the result is shown, so the length of the
// row sets how often items are taken.
// Checks report a hit and the access address if an active slot overlaps the
// access and fits its direction. Adds fill the next never-used slot; removed
// slots are not reused, and a table that has filled every slot refuses adds.
// Reset clears every active mark, the fill count and any item in flight;
// slot contents are only ever read once written.
module watchpoint_range_unit #(
   parameter int ENTRIES = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire wru_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   output wru_pkg::rsp_item_type      rsp_item
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   wru_pkg::token_type     tok [ENTRIES+1];
   wru_pkg::token_type     head_ff, head_in, last;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic                   busy_ff, busy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   wru_pkg::rsp_item_type  rsp_ff, rsp_in;
   logic                   accept;
   logic [ENTRIES:0]       tok_valids;

   assign accept = start && !busy_ff;
   assign last   = tok[ENTRIES];

   always_comb begin
      head_in.valid = accept;
      head_in.op    = req_item.req_type;
      head_in.addr  = req_item.addr;
      head_in.len   = req_item.len;
      head_in.sum   = req_item.addr + req_item.len;
      head_in.kind  = req_item.wp_kind;
      head_in.wr    = req_item.access_wr;
      head_in.done  = 1'b0;
      head_in.wrote = 1'b0;
   end

   assign tok[0] = head_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      wru_cell #(
         .ENTRIES (ENTRIES),
         .INDEX   (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .used_count (used_ff),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1])
      );
   end

   for (genvar i = 0; i <= ENTRIES; i++) begin : g_valid
      assign tok_valids[i] = tok[i].valid;
   end

   always_comb begin
      rsp_valid_in    = last.valid;
      rsp_in.status   = 1'b0;
      rsp_in.hit      = 1'b0;
      rsp_in.hit_addr = '0;
      used_in         = used_ff;
      case (last.op)
         wru_pkg::REQ_CHECK: begin
            rsp_in.hit      = last.done;
            rsp_in.hit_addr = last.done ? last.addr : '0;
         end
         wru_pkg::REQ_ADD: begin
            rsp_in.status = !last.done;
            if (last.valid && last.wrote) used_in = used_ff + CNT_W'(1);
         end
         wru_pkg::REQ_REMOVE: rsp_in.status = !last.done;
         default: ;
      endcase

      busy_in = busy_ff;
      if (accept)          busy_in = 1'b1;
      else if (last.valid) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
         used_ff       <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff      <= head_in;
         used_ff      <= used_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef ASSERT_OFF
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valids))
      else $error("more than one item in the slot row");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("result shown while still busy");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond table size");

   a_busy_while_walking: assert property (@(posedge clock) disable iff (reset)
      (|tok_valids) |-> busy_ff)
      else $error("item in flight while not busy");
`endif

endmodule

`default_nettype wire

FILE: sim/wru_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the watchpoint unit, keeps its own copy of the
// table and checks every result against the outcome predicted for its item.
module wru_checker #(
   parameter int ENTRIES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  wru_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  wru_pkg::rsp_item_type rsp_item,
   output int                    errors,
   output int                    outstanding
);

   logic [wru_pkg::ADDR_W-1:0] slot_addr [ENTRIES];
   logic [wru_pkg::ADDR_W-1:0] slot_len  [ENTRIES];
   logic [wru_pkg::KIND_W-1:0] slot_kind [ENTRIES];
   logic                       slot_live [ENTRIES];
   int                         slots_filled;
   wru_pkg::rsp_item_type      awaited_rsp [$];

   task automatic note_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   // first live slot holding exactly this watchpoint, or -1
   function automatic int find_slot(input logic [wru_pkg::ADDR_W-1:0] a,
                                    input logic [wru_pkg::ADDR_W-1:0] l,
                                    input logic [wru_pkg::KIND_W-1:0] k);
      for (int i = 0; i < slots_filled; i++)
         if (slot_live[i] && slot_addr[i] == a && slot_len[i] == l && slot_kind[i] == k)
            return i;
      return -1;
   endfunction

   task automatic resolve_request(input wru_pkg::req_item_type rq,
                                  output wru_pkg::rsp_item_type res);
      int                         s;
      logic                       fits;
      logic [wru_pkg::ADDR_W-1:0] acc_end;
      logic [wru_pkg::ADDR_W-1:0] slot_end;
      res = '0;
      case (rq.req_type)
         wru_pkg::REQ_CHECK: begin
            acc_end = rq.addr + rq.len;
            for (int i = 0; i < slots_filled && !res.hit; i++) begin
               slot_end = slot_addr[i] + slot_len[i];
               fits = (slot_kind[i] == wru_pkg::KIND_ACCESS) ||
                      (slot_kind[i] == wru_pkg::KIND_WRITE && rq.access_wr) ||
                      (slot_kind[i] == wru_pkg::KIND_READ && !rq.access_wr);
               // both ends wrap, so the test is taken literally
               if (slot_live[i] && fits && acc_end > slot_addr[i] && rq.addr < slot_end) begin
                  res.hit      = 1'b1;
                  res.hit_addr = rq.addr;
               end
            end
         end
         wru_pkg::REQ_ADD: begin
            if (rq.wp_kind > wru_pkg::KIND_ACCESS)
               res.status = 1'b1;
            else if (find_slot(rq.addr, rq.len, rq.wp_kind) < 0) begin
               if (slots_filled >= ENTRIES)
                  res.status = 1'b1;
               else begin
                  slot_addr[slots_filled] = rq.addr;
                  slot_len[slots_filled]  = rq.len;
                  slot_kind[slots_filled] = rq.wp_kind;
                  slot_live[slots_filled] = 1'b1;
                  slots_filled++;
               end
            end
         end
         wru_pkg::REQ_REMOVE: begin
            s = (rq.wp_kind > wru_pkg::KIND_ACCESS) ? -1
                : find_slot(rq.addr, rq.len, rq.wp_kind);
            if (s < 0)
               res.status = 1'b1;
            else
               slot_live[s] = 1'b0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      wru_pkg::rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++)
            slot_live[i] = 1'b0;
         slots_filled = 0;
         awaited_rsp.delete();
         errors = 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0)
               note_error($sformatf("result with no item waiting: status %b hit %b addr %h",
                                    rsp_item.status, rsp_item.hit, rsp_item.hit_addr));
            else begin
               want = awaited_rsp.pop_front();
               if (rsp_item.status !== want.status)
                  note_error($sformatf("status %b, predicted %b", rsp_item.status, want.status));
               if (rsp_item.hit !== want.hit)
                  note_error($sformatf("hit %b, predicted %b", rsp_item.hit, want.hit));
               if (rsp_item.hit_addr !== want.hit_addr)
                  note_error($sformatf("hit_addr %h, predicted %h",
                                       rsp_item.hit_addr, want.hit_addr));
            end
         end
         if (start && !busy) begin
            resolve_request(req_item, want);
            awaited_rsp.push_back(want);
         end
      end
      outstanding <= awaited_rsp.size();
   end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int ENTRIES    = 32;
   localparam int ITEM_TOTAL = 900;
   localparam int IDLE_LIMIT = 1000;

   localparam logic [wru_pkg::OP_W-1:0]   REQ_UNKNOWN = 2'd3;
   localparam logic [wru_pkg::KIND_W-1:0] KIND_BAD    = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   wru_pkg::req_item_type req_item = '0;
   logic                  rsp_valid;
   wru_pkg::rsp_item_type rsp_item;
   int                    errors;
   int                    outstanding;
   int                    idle_cycles = 0;
   int                    sent = 0;
   int                    burst_left = 0;
   wru_pkg::req_item_type placed_wp [$];

   always #4 clock = ~clock;

   watchpoint_range_unit #(.ENTRIES(ENTRIES)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   wru_checker #(.ENTRIES(ENTRIES)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .errors      (errors),
      .outstanding (outstanding)
   );

   function automatic wru_pkg::req_item_type make_req(
         input logic [wru_pkg::OP_W-1:0]   op,
         input logic [wru_pkg::ADDR_W-1:0] a,
         input logic [wru_pkg::ADDR_W-1:0] l,
         input logic [wru_pkg::KIND_W-1:0] k,
         input logic                       w);
      wru_pkg::req_item_type it;
      it.req_type  = op;
      it.addr      = a;
      it.len       = l;
      it.wp_kind   = k;
      it.access_wr = w;
      return it;
   endfunction

   function automatic logic [wru_pkg::ADDR_W-1:0] pick_addr();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 'hFFFF);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [wru_pkg::ADDR_W-1:0] pick_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return $urandom_range(1, 64);
      if (r < 14) return '0;
      if (r < 17) return $urandom;
      return 32'hFFFF_FFFF - $urandom_range(0, 255);
   endfunction

   // sender works in bursts; a gap may open before each burst
   task automatic send_item(input wru_pkg::req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 40);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_item <= it;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sent++;
      if (it.req_type == wru_pkg::REQ_ADD && it.wp_kind <= wru_pkg::KIND_ACCESS)
         placed_wp.push_back(it);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic send_random();
      wru_pkg::req_item_type it;
      wru_pkg::req_item_type known;
      int                    r;
      it = make_req(wru_pkg::REQ_CHECK, pick_addr(), pick_len(),
                    wru_pkg::KIND_W'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
      known = it;
      if (placed_wp.size() != 0)
         known = placed_wp[$urandom_range(0, placed_wp.size() - 1)];
      r = $urandom_range(0, 99);
      // adds kept rare so the table fills only late in the run
      if (r < 5)
         it.req_type = wru_pkg::REQ_ADD;
      else if (r < 9) begin
         it = make_req(wru_pkg::REQ_ADD, known.addr, known.len, known.wp_kind,
                       1'($urandom_range(0, 1)));
      end else if (r < 17) begin
         it = make_req(wru_pkg::REQ_REMOVE, known.addr, known.len, known.wp_kind,
                       1'($urandom_range(0, 1)));
      end else if (r < 20)
         it.req_type = wru_pkg::REQ_REMOVE;
      else if (r < 23)
         it = make_req(REQ_UNKNOWN, $urandom, $urandom, wru_pkg::KIND_W'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)));
      else if (r < 25) begin
         it.req_type = r[0] ? wru_pkg::REQ_ADD : wru_pkg::REQ_REMOVE;
         it.wp_kind  = KIND_BAD;
      end else begin
         it.wp_kind = wru_pkg::KIND_W'($urandom_range(0, 3));
         if (r < 75) begin
            it.addr = known.addr + $urandom_range(0, 80) - 40;
            it.len  = $urandom_range(0, 48);
         end
      end
      send_item(it);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_item(make_req(wru_pkg::REQ_CHECK,  32'h0000_0000, 32'h4, wru_pkg::KIND_WRITE, 1'b1));
      send_item(make_req(wru_pkg::REQ_ADD,    32'h0000_1000, 32'h8, wru_pkg::KIND_WRITE, 1'b0));
      send_item(make_req(wru_pkg::REQ_ADD,    32'h0000_1000, 32'h8, wru_pkg::KIND_WRITE, 1'b1));
      send_item(make_req(wru_pkg::REQ_CHECK,  32'h0000_1004, 32'h1, wru_pkg::KIND_WRITE, 1'b1));
      send_item(make_req(wru_pkg::REQ_CHECK,  32'h0000_1004, 32'h1, wru_pkg::KIND_WRITE, 1'b0));
      // access ending exactly at the slot start, then one starting at its end
      send_item(make_req(wru_pkg::REQ_CHECK,  32'h0000_0FF8, 32'h8, wru_pkg::KIND_WRITE, 1'b1));
      send_item(make_req(wru_pkg::REQ_CHECK,  32'h0000_1008, 32'h4, wru_pkg::KIND_WRITE, 1'b1));
      send_item(make_req(wru_pkg::REQ_CHECK,  32'h0000_0FF9, 32'h8, wru_pkg::KIND_WRITE, 1'b1));
      // slot whose end wraps past zero
      send_item(make_req(wru_pkg::REQ_ADD,    32'hFFFF_FFF0, 32'h20, wru_pkg::KIND_READ, 1'b0));
      send_item(make_req(wru_pkg::REQ_CHECK,  32'hFFFF_FFF8, 32'h4, wru_pkg::KIND_READ, 1'b0));
      send_item(make_req(wru_pkg::REQ_CHECK,  32'h0000_0000, 32'hFFFF_FFFF,
                         wru_pkg::KIND_ACCESS, 1'b0));
      send_item(make_req(wru_pkg::REQ_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         wru_pkg::KIND_ACCESS, 1'b1));
      send_item(make_req(wru_pkg::REQ_ADD,    32'h0000_3000, 32'h10, KIND_BAD, 1'b0));
      send_item(make_req(wru_pkg::REQ_REMOVE, 32'h0000_1000, 32'h8, KIND_BAD, 1'b0));
      send_item(make_req(wru_pkg::REQ_REMOVE, 32'h0000_5000, 32'h8, wru_pkg::KIND_READ, 1'b0));
      send_item(make_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_BAD, 1'b1));
      send_item(make_req(wru_pkg::REQ_CHECK,  32'h0000_1004, 32'h0, wru_pkg::KIND_WRITE, 1'b1));
      // zero-length slot
      send_item(make_req(wru_pkg::REQ_ADD,    32'h0000_2000, 32'h0, wru_pkg::KIND_ACCESS, 1'b0));
      send_item(make_req(wru_pkg::REQ_CHECK,  32'h0000_1FFF, 32'h2, wru_pkg::KIND_ACCESS, 1'b1));
      send_item(make_req(wru_pkg::REQ_REMOVE, 32'h0000_1000, 32'h8, wru_pkg::KIND_WRITE, 1'b1));
      send_item(make_req(wru_pkg::REQ_CHECK,  32'h0000_1004, 32'h1, wru_pkg::KIND_WRITE, 1'b1));
      send_item(make_req(wru_pkg::REQ_REMOVE, 32'h0000_1000, 32'h8, wru_pkg::KIND_WRITE, 1'b1));
      send_item(make_req(wru_pkg::REQ_ADD,    32'h0000_1000, 32'h8, wru_pkg::KIND_WRITE, 1'b0));
      send_item(make_req(wru_pkg::REQ_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_BAD, 1'b1));
      wait_drained();

      while (sent < ITEM_TOTAL) begin
         send_random();
         if (sent == ITEM_TOTAL / 2)
            wait_drained();
      end

      wait_drained();
      repeat (2 * ENTRIES + 8) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog: too long with neither an item taken nor a result shown
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else if (idle_cycles == IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule
